// ===== rtl/core/bbts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbts_pkg: shared types and constants of the branch and block-transfer sequencer
// Holds the sequencer states, the result kind codes and the step unit controls.
// ----------------------------------------------------------------------------
package bbts_pkg;

    // Instruction bit positions.
    localparam int BIT_BRANCH = 25;
    localparam int BIT_PRE    = 24;   // P on a block transfer, L on a branch
    localparam int BIT_UP     = 23;
    localparam int BIT_WB     = 21;
    localparam int BIT_LOAD   = 20;

    localparam int NUM_REGS   = 16;
    localparam int REG_BITS   = 4;
    localparam int OFF_BITS   = 24;

    // Result kind codes.
    localparam logic [1:0] KIND_BRANCH = 2'd0;
    localparam logic [1:0] KIND_ACCESS = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BR_PC4,
        ST_BR_OFF,
        ST_EMPTY,
        ST_SCAN
    } state_t;

    typedef enum logic [1:0] {
        OP_PC_PLUS4,
        OP_ADD_OFFSET,
        OP_ADD_STEP
    } step_op_t;

    typedef struct packed {
        step_op_t op;
        logic     up;
    } step_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/bbts_step_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbts_step_unit: shared 32-bit address adder
// Selects the operands for the pc increment, the branch offset add or the
// block-transfer address step, and adds them in one 32-bit adder.
// ----------------------------------------------------------------------------
module bbts_step_unit
    import bbts_pkg::*;
(
    input  step_ctrl_t               ctrl,
    input  logic [31:0]              acc,
    input  logic [31:0]              pc,
    input  logic [OFF_BITS-1:0]      offset,
    output logic [31:0]              sum
);

    logic [31:0] op_a;
    logic [31:0] op_b;

    always_comb
    begin
        case (ctrl.op)
            OP_PC_PLUS4:
            begin
                op_a = pc;
                op_b = 32'd4;
            end
            OP_ADD_OFFSET:
            begin
                op_a = acc;
                op_b = {{(32 - OFF_BITS - 2){offset[OFF_BITS-1]}}, offset, 2'b00};
            end
            OP_ADD_STEP:
            begin
                op_a = acc;
                op_b = ctrl.up ? 32'd4 : 32'hFFFF_FFFC;
            end
            default:
            begin
                op_a = acc;
                op_b = 32'd0;
            end
        endcase
        sum = op_a + op_b;
    end

endmodule

`default_nettype wire

// ===== rtl/core/branch_and_block_transfer_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// branch_and_block_transfer_sequencer: branch target and block-transfer
// address sequencer
// Takes one instruction item and gives a branch result, an empty-list result
// or one access item per listed register, with link and base writeback data.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload
//  -------  -------------------  ---------------------------------------------
//  in       in_valid / in_stall  instruction, pc_value, base_value
//  out      out_valid/out_stall  result_kind, address, reg_index, is_load,
//                                link_write, link_value, writeback_en,
//                                writeback_value, last
//
// A branch uses the shared adder after acceptance for pc + 4, then for the
// scaled offset. A block transfer walks the register slots in walk order,
// one slot per cycle while the output slot is free, and stops at the last
// listed register. An empty list gives one result with no address step.
// All of these steps share the single adder.
// Reset is asynchronous and active low; it clears the sequencer and the
// output valid. The input stalls whenever an item is in work. A stall on the
// output holds the sequencer wherever it has a result item to place, until
// the waiting result item is taken.
// ----------------------------------------------------------------------------
module branch_and_block_transfer_sequencer
    import bbts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] instruction,
    input  logic [31:0] pc_value,
    input  logic [31:0] base_value,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [31:0] address,
    output logic [3:0]  reg_index,
    output logic        is_load,
    output logic        link_write,
    output logic [31:0] link_value,
    output logic        writeback_en,
    output logic [31:0] writeback_value,
    output logic        last
);

    // Sequencer state and the fields of the instruction in work.
    state_t                 state_reg, state_next;
    logic [NUM_REGS-1:0]    remaining_reg, remaining_next;
    logic [REG_BITS-1:0]    slot_reg, slot_next;
    logic [31:0]            acc_reg, acc_next;
    logic [31:0]            pc_reg, pc_next;
    logic [OFF_BITS-1:0]    offset_reg, offset_next;
    logic                   pre_reg, pre_next;
    logic                   up_reg, up_next;
    logic                   ld_reg, ld_next;
    logic                   wb_reg, wb_next;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             kind_reg, kind_next;
    logic [31:0]            address_reg, address_next;
    logic [3:0]             reg_index_reg, reg_index_next;
    logic                   is_load_reg, is_load_next;
    logic                   link_write_reg, link_write_next;
    logic [31:0]            link_value_reg, link_value_next;
    logic                   wb_en_reg, wb_en_next;
    logic [31:0]            wb_value_reg, wb_value_next;
    logic                   last_reg, last_next;

    step_ctrl_t             step_ctrl;
    logic [31:0]            step_sum;
    logic                   out_free;
    logic [REG_BITS-1:0]    cur_reg;
    logic [NUM_REGS-1:0]    remaining_clr;
    logic                   fin;

    bbts_step_unit u_step
    (
        .ctrl   (step_ctrl),
        .acc    (acc_reg),
        .pc     (pc_reg),
        .offset (offset_reg),
        .sum    (step_sum)
    );

    // The output slot can take a new result item when it is empty or
    // its item is being taken in this cycle.
    assign out_free = !out_valid_reg || !out_stall;

    // Ascending walks visit r0 first; descending walks visit r15 first.
    assign cur_reg       = up_reg ? slot_reg : ~slot_reg;
    assign remaining_clr = remaining_reg & ~(NUM_REGS'(1) << cur_reg);
    assign fin           = (remaining_clr == '0);

    always_comb
    begin
        state_next      = state_reg;
        remaining_next  = remaining_reg;
        slot_next       = slot_reg;
        acc_next        = acc_reg;
        pc_next         = pc_reg;
        offset_next     = offset_reg;
        pre_next        = pre_reg;
        up_next         = up_reg;
        ld_next         = ld_reg;
        wb_next         = wb_reg;

        out_valid_next  = out_valid_reg && out_stall;
        kind_next       = kind_reg;
        address_next    = address_reg;
        reg_index_next  = reg_index_reg;
        is_load_next    = is_load_reg;
        link_write_next = link_write_reg;
        link_value_next = link_value_reg;
        wb_en_next      = wb_en_reg;
        wb_value_next   = wb_value_reg;
        last_next       = last_reg;

        step_ctrl.op    = OP_ADD_STEP;
        step_ctrl.up    = up_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    remaining_next = instruction[NUM_REGS-1:0];
                    slot_next      = '0;
                    acc_next       = base_value;
                    pc_next        = pc_value;
                    offset_next    = instruction[OFF_BITS-1:0];
                    pre_next       = instruction[BIT_PRE];
                    up_next        = instruction[BIT_UP];
                    ld_next        = instruction[BIT_LOAD];
                    wb_next        = instruction[BIT_WB];
                    if (instruction[BIT_BRANCH])
                        state_next = ST_BR_PC4;
                    else if (instruction[NUM_REGS-1:0] == '0)
                        state_next = ST_EMPTY;
                    else
                        state_next = ST_SCAN;
                end
            end

            ST_BR_PC4:
            begin
                step_ctrl.op = OP_PC_PLUS4;
                acc_next     = step_sum;
                state_next   = ST_BR_OFF;
            end

            ST_BR_OFF:
            begin
                step_ctrl.op = OP_ADD_OFFSET;
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    kind_next       = KIND_BRANCH;
                    address_next    = step_sum;
                    reg_index_next  = '0;
                    is_load_next    = 1'b0;
                    link_write_next = pre_reg;
                    link_value_next = pre_reg ? pc_reg : 32'd0;
                    wb_en_next      = 1'b0;
                    wb_value_next   = 32'd0;
                    last_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    kind_next       = KIND_EMPTY;
                    address_next    = 32'd0;
                    reg_index_next  = '0;
                    is_load_next    = 1'b0;
                    link_write_next = 1'b0;
                    link_value_next = 32'd0;
                    wb_en_next      = wb_reg;
                    wb_value_next   = wb_reg ? acc_reg : 32'd0;
                    last_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (out_free)
                begin
                    slot_next = slot_reg + 1'b1;
                    if (remaining_reg[cur_reg])
                    begin
                        acc_next        = step_sum;
                        remaining_next  = remaining_clr;
                        out_valid_next  = 1'b1;
                        kind_next       = KIND_ACCESS;
                        address_next    = pre_reg ? step_sum : acc_reg;
                        reg_index_next  = cur_reg;
                        is_load_next    = ld_reg;
                        link_write_next = 1'b0;
                        link_value_next = 32'd0;
                        wb_en_next      = fin && wb_reg;
                        wb_value_next   = (fin && wb_reg) ? step_sum : 32'd0;
                        last_next       = fin;
                        if (fin)
                            state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            remaining_reg <= '0;
            slot_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            remaining_reg <= remaining_next;
            slot_reg      <= slot_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        acc_reg        <= acc_next;
        pc_reg         <= pc_next;
        offset_reg     <= offset_next;
        pre_reg        <= pre_next;
        up_reg         <= up_next;
        ld_reg         <= ld_next;
        wb_reg         <= wb_next;
        kind_reg       <= kind_next;
        address_reg    <= address_next;
        reg_index_reg  <= reg_index_next;
        is_load_reg    <= is_load_next;
        link_write_reg <= link_write_next;
        link_value_reg <= link_value_next;
        wb_en_reg      <= wb_en_next;
        wb_value_reg   <= wb_value_next;
        last_reg       <= last_next;
    end

    assign in_stall        = (state_reg != ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign result_kind     = kind_reg;
    assign address         = address_reg;
    assign reg_index       = reg_index_reg;
    assign is_load         = is_load_reg;
    assign link_write      = link_write_reg;
    assign link_value      = link_value_reg;
    assign writeback_en    = wb_en_reg;
    assign writeback_value = wb_value_reg;
    assign last            = last_reg;

    // A scan never runs with nothing left to transfer.
    a_scan_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> remaining_reg != '0)
        else $error("scan running with an empty register list");

    // A walk that reaches the final slot always ends on it.
    a_scan_ends_on_time: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && slot_reg == '1 && out_free) |=> state_reg == ST_IDLE)
        else $error("scan did not finish on its last slot");

    // The item marked last always returns the sequencer to idle.
    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && out_valid_next && last_next && out_free)
        |=> state_reg == ST_IDLE)
        else $error("last result issued but sequencer still busy");

    // A branch result is always the only one of its instruction.
    a_branch_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_BRANCH) |-> last_reg)
        else $error("branch result without last");

endmodule

`default_nettype wire

// ===== dv/tb_branch_and_block_transfer_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_branch_and_block_transfer_sequencer: self-checking bench for the sequencer
// Feeds branch and block-transfer instruction items and predicts every result
// item in a scoreboard. Each result that the block gives up is compared field
// by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_branch_and_block_transfer_sequencer;
    import bbts_pkg::*;

    // A run with no handshake on either side for this many cycles is hung.
    // The slowest correct item walks sixteen register slots, and random stalls
    // end by chance, so this leaves a wide margin.
    localparam int unsigned HANG_CYCLES  = 2000;
    // Cycles to wait after the last predicted item, so that a stray extra
    // result still shows up. One full slot sweep plus some slack.
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned RANDOM_ITEMS = 300;

    // One result item, with the same fields as the output ports.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [3:0]  reg_index;
        logic        is_load;
        logic        link_write;
        logic [31:0] link_value;
        logic        writeback_en;
        logic [31:0] writeback_value;
        logic        last;
    } transfer_result_t;

    // The scoreboard expands each accepted instruction into the result items
    // it must cause and matches them, in order, against what comes out.
    class transfer_scoreboard;
        transfer_result_t pending_results[$];
        int unsigned      errors;

        function new();
            errors = 0;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function void note_instruction(logic [31:0] word, logic [31:0] pc,
                                       logic [31:0] base);
            transfer_result_t r;
            logic [31:0]          offset;
            logic [31:0]          step;
            logic [31:0]          addr;
            logic [15:0]          left;
            logic [REG_BITS-1:0]  rn;

            r = '0;
            if (word[BIT_BRANCH])
            begin
                // Word offset, sign-extended and scaled by four.
                offset = {{(32 - OFF_BITS - 2){word[OFF_BITS-1]}},
                          word[OFF_BITS-1:0], 2'b00};
                r.kind       = KIND_BRANCH;
                r.address    = pc + offset + 32'd4;
                r.link_write = word[BIT_PRE];
                r.link_value = word[BIT_PRE] ? pc : 32'd0;
                r.last       = 1'b1;
                pending_results.push_back(r);
            end
            else if (word[NUM_REGS-1:0] == '0)
            begin
                // Empty list: one result with no access, base kept as is.
                r.kind            = KIND_EMPTY;
                r.writeback_en    = word[BIT_WB];
                r.writeback_value = word[BIT_WB] ? base : 32'd0;
                r.last            = 1'b1;
                pending_results.push_back(r);
            end
            else
            begin
                step = word[BIT_UP] ? 32'd4 : 32'hFFFF_FFFC;
                addr = base;
                left = word[NUM_REGS-1:0];
                for (int slot = 0; slot < NUM_REGS; slot++)
                begin
                    rn = word[BIT_UP] ? REG_BITS'(slot) : REG_BITS'(NUM_REGS - 1 - slot);
                    if (left[rn])
                    begin
                        r = '0;
                        if (word[BIT_PRE])
                        begin
                            addr = addr + step;
                        end
                        r.kind      = KIND_ACCESS;
                        r.address   = addr;
                        r.reg_index = rn;
                        r.is_load   = word[BIT_LOAD];
                        if (!word[BIT_PRE])
                        begin
                            addr = addr + step;
                        end
                        left[rn] = 1'b0;
                        if (left == '0)
                        begin
                            r.last            = 1'b1;
                            r.writeback_en    = word[BIT_WB];
                            r.writeback_value = word[BIT_WB] ? addr : 32'd0;
                        end
                        pending_results.push_back(r);
                    end
                end
            end
        endfunction

        task check_result(transfer_result_t got);
            transfer_result_t want;

            if (pending_results.size() == 0)
            begin
                report($sformatf("result item with nothing predicted, address %h",
                                 got.address));
                return;
            end
            want = pending_results.pop_front();
            if (got.kind != want.kind)
                report($sformatf("result_kind %0d, predicted %0d", got.kind, want.kind));
            if (got.address != want.address)
                report($sformatf("address %h, predicted %h", got.address, want.address));
            if (got.reg_index != want.reg_index)
                report($sformatf("reg_index %0d, predicted %0d",
                                 got.reg_index, want.reg_index));
            if (got.is_load != want.is_load)
                report($sformatf("is_load %b, predicted %b", got.is_load, want.is_load));
            if (got.link_write != want.link_write)
                report($sformatf("link_write %b, predicted %b",
                                 got.link_write, want.link_write));
            if (got.link_value != want.link_value)
                report($sformatf("link_value %h, predicted %h",
                                 got.link_value, want.link_value));
            if (got.writeback_en != want.writeback_en)
                report($sformatf("writeback_en %b, predicted %b",
                                 got.writeback_en, want.writeback_en));
            if (got.writeback_value != want.writeback_value)
                report($sformatf("writeback_value %h, predicted %h",
                                 got.writeback_value, want.writeback_value));
            if (got.last != want.last)
                report($sformatf("last %b, predicted %b", got.last, want.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] instruction;
    logic [31:0] pc_value;
    logic [31:0] base_value;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  result_kind;
    logic [31:0] address;
    logic [3:0]  reg_index;
    logic        is_load;
    logic        link_write;
    logic [31:0] link_value;
    logic        writeback_en;
    logic [31:0] writeback_value;
    logic        last;

    // When low, neither side idles: the sender keeps valid up and the
    // receiver never stalls.
    logic        gaps_on;
    int unsigned quiet_cycles;

    transfer_scoreboard scoreboard;

    branch_and_block_transfer_sequencer i_dut (.*);

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Branch instruction word: bit 25 set, L in bit 24, 24-bit word offset.
    function automatic logic [31:0] branch_word(logic [23:0] offset, logic link);
        return {6'b0, 1'b1, link, offset};
    endfunction

    // Block-transfer instruction word with bit 22 and the top bits clear.
    function automatic logic [31:0] block_word(logic [15:0] list, logic [3:0] rn,
                                               logic load, logic wb, logic up,
                                               logic pre);
        return {6'b0, 1'b0, pre, up, 1'b0, wb, load, rn, list};
    endfunction

    // Offers one instruction item, with a random gap in front when gaps are
    // on, and holds it until the block takes it. It returns at the accepting
    // edge with valid still high, so that a following item can go straight
    // out without valid dropping in between.
    task automatic send_instruction(logic [31:0] word, logic [31:0] pc,
                                    logic [31:0] base);
        while (gaps_on && ($urandom_range(0, 99) < 20))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        instruction <= word;
        pc_value    <= pc;
        base_value  <= base;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        scoreboard.note_instruction(word, pc, base);
    endtask

    // Receiver: stalls about one cycle in five while gaps are on.
    always @(posedge clk)
    begin
        out_stall <= gaps_on && ($urandom_range(0, 99) < 20);
    end

    // Every result item taken by the receiver goes to the scoreboard. The
    // ports are read at the edge, before the block updates them.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            scoreboard.check_result('{result_kind, address, reg_index, is_load,
                                      link_write, link_value, writeback_en,
                                      writeback_value, last});
        end
    end

    // Watchdog: the run is declared hung when neither channel moves an item
    // while the quiet count climbs to HANG_CYCLES.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= HANG_CYCLES)
        begin
            $display("[%0t] no handshake for %0d cycles", $realtime, HANG_CYCLES);
            $display("FAILED: results differ");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        logic [31:0] word;
        logic [31:0] pc;
        logic [31:0] base;
        int unsigned pick;

        scoreboard   = new();
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        instruction <= 32'd0;
        pc_value    <= 32'd0;
        base_value  <= 32'd0;
        out_stall   <= 1'b0;
        gaps_on     <= 1'b1;
        quiet_cycles = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Branches: zero offset, the largest forward and backward offsets,
        // minus one word, with and without link, and pc values that wrap.
        send_instruction(branch_word(24'h000000, 1'b0), 32'h0000_1000, 32'h0000_0000);
        send_instruction(branch_word(24'h7FFFFF, 1'b1), 32'hFFFF_FFFC, 32'hFFFF_FFFF);
        send_instruction(branch_word(24'h800000, 1'b1), 32'h0000_0000, 32'hA5A5_A5A5);
        send_instruction(branch_word(24'hFFFFFF, 1'b0), 32'h0000_0004, 32'h0000_0000);
        // Every bit set: a branch with link whose top bits are all ones.
        send_instruction(32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000);

        // Empty lists, with and without writeback.
        send_instruction(block_word(16'h0000, 4'd3, 1'b0, 1'b1, 1'b1, 1'b1),
                         32'h0000_0100, 32'hFFFF_FFFF);
        send_instruction(block_word(16'h0000, 4'd0, 1'b1, 1'b0, 1'b0, 1'b0),
                         32'h0000_0200, 32'h1234_5678);

        // Full lists. Every bit but the branch bit set: full load with
        // writeback, the ignored bit 22 and the base in the list, wrapping up.
        send_instruction(32'hFDFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
        send_instruction(block_word(16'hFFFF, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0),
                         32'h0000_0000, 32'h0000_0000);

        // The first and last registers under all four step modes.
        send_instruction(block_word(16'h8001, 4'd1, 1'b1, 1'b1, 1'b0, 1'b0),
                         32'h0000_0010, 32'h0000_1000);
        send_instruction(block_word(16'h8001, 4'd1, 1'b0, 1'b1, 1'b0, 1'b1),
                         32'h0000_0010, 32'h0000_1000);
        send_instruction(block_word(16'h8001, 4'd1, 1'b1, 1'b1, 1'b1, 1'b0),
                         32'h0000_0010, 32'h0000_1000);
        send_instruction(block_word(16'h8001, 4'd1, 1'b0, 1'b1, 1'b1, 1'b1),
                         32'h0000_0010, 32'h0000_1000);

        // Single registers at either end, stepping across zero.
        send_instruction(block_word(16'h0001, 4'd7, 1'b1, 1'b1, 1'b0, 1'b1),
                         32'h0000_0020, 32'h0000_0000);
        send_instruction(block_word(16'h8000, 4'd7, 1'b0, 1'b1, 1'b1, 1'b0),
                         32'h0000_0020, 32'hFFFF_FFFC);

        // Base register in the list: load with writeback, store with
        // writeback, load without writeback.
        send_instruction(block_word(16'h0124, 4'd5, 1'b1, 1'b1, 1'b1, 1'b0),
                         32'h0000_0030, 32'h0000_4000);
        send_instruction(block_word(16'h0124, 4'd5, 1'b0, 1'b1, 1'b0, 1'b1),
                         32'h0000_0030, 32'h0000_4000);
        send_instruction(block_word(16'h0124, 4'd5, 1'b1, 1'b0, 1'b1, 1'b1),
                         32'h0000_0030, 32'h0000_4000);

        // Bit 22 set on an otherwise ordinary transfer must change nothing.
        send_instruction(block_word(16'h00F0, 4'd2, 1'b1, 1'b1, 1'b0, 1'b1)
                         | 32'h0040_0000, 32'h0000_0040, 32'h8000_0000);

        // Random items. A stretch in the middle runs with no gaps on either
        // side, so the block is also seen at its full rate.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            gaps_on <= !(n >= 100 && n < 170);
            word = $urandom;
            pc   = $urandom;
            pick = $urandom_range(0, 3);
            if (pick == 0)
            begin
                base = 32'hFFFF_FFC0 + $urandom_range(0, 127);
            end
            else
            begin
                base = $urandom;
            end
            if ($urandom_range(0, 99) < 30)
            begin
                word[BIT_BRANCH] = 1'b1;
            end
            else
            begin
                word[BIT_BRANCH] = 1'b0;
                pick = $urandom_range(0, 9);
                case (pick)
                    0: word[15:0] = 16'h0000;
                    1: word[15:0] = 16'hFFFF;
                    2, 3: word[15:0] = 16'h0001 << $urandom_range(0, 15);
                    default: ;
                endcase
                // Now and then put the base register into a non-empty list.
                if (pick != 0 && $urandom_range(0, 3) == 0)
                begin
                    word[word[19:16]] = 1'b1;
                end
            end
            send_instruction(word, pc, base);
        end
        in_valid <= 1'b0;

        // Let every predicted item come out, then watch a little longer for
        // anything extra. The watchdog ends the run if the block hangs.
        while (scoreboard.pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (scoreboard.errors == 0 && scoreboard.pending_results.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== branch_and_block_transfer_sequencer.f =====
rtl/core/bbts_pkg.sv
rtl/core/bbts_step_unit.sv
rtl/core/branch_and_block_transfer_sequencer.sv
dv/tb_branch_and_block_transfer_sequencer.sv
